### rtl/icl_pkg.sv
// icl_pkg: shared constants for the inode cache
// used by icl_div and inode_cache_lfu_top
`timescale 1ns / 1ps
package icl_pkg;
	localparam int DEF_ENTRIES = 64;
	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;
	localparam logic [2:0] ST_HIT      = 3'd0;
	localparam logic [2:0] ST_FILL     = 3'd1;
	localparam logic [2:0] ST_EVICT    = 3'd2;
	localparam logic [2:0] ST_NONE     = 3'd3;
	localparam logic [2:0] ST_RELEASE  = 3'd4;
	localparam logic [2:0] ST_WBACK    = 3'd5;
	localparam logic [2:0] ST_BADPUT   = 3'd6;
	localparam logic CFG_IPB   = 1'b0;
	localparam logic CFG_START = 1'b1;
	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [6:0]  divisor;
	} div_req_t;
endpackage

### rtl/icl_div.sv
// icl_div: restoring divider, one quotient bit per cycle
// depends on icl_pkg for the request struct
`timescale 1ns / 1ps
module icl_div (
	input  logic              clk,
	input  logic              arst_n,
	input  icl_pkg::div_req_t req,
	output logic              done,
	output logic [31:0]       quot,
	output logic [6:0]        rem
);
	logic [31:0] q_q;
	logic [6:0]  r_q;
	logic [6:0]  d_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [7:0]  trial;
	assign trial = {r_q, q_q[31]} - {1'b0, d_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q <= req.dividend;
			r_q <= '0;
			d_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[7]) begin
				r_q <= trial[6:0];
				q_q <= {q_q[30:0], 1'b1};
			end else begin
				r_q <= {r_q[5:0], q_q[31]};
				q_q <= {q_q[30:0], 1'b0};
			end
		end
	end
	assign quot = q_q;
	assign rem  = r_q;
endmodule

### rtl/inode_cache_lfu_top.sv
// inode_cache_lfu_top: fully associative inode cache with lfu replacement
// depends on icl_pkg and icl_div
//
// usage: one command word enters on in_valid/in_stall, one result word
// leaves on out_valid/out_stall. a get scans the entries for a match,
// then (on a miss) once more for a free slot or the victim with the
// smallest use count among entries with a zero share count, then divides
// inode-1 by inodes_per_block in the shared 32-step divider, one bit per
// cycle. a get with no victim skips the divide; a put divides too, an
// invalid put does not.
// in_stall is high from acceptance until the result is taken. a stalled
// result holds its word. reset frees every slot at once through per-slot
// valid bits and clears both running counts; configuration returns to
// 8 and 0. registers are written through cfg_we/cfg_index/cfg_data; the
// user must write them only while idle, the block does not enforce it.
`timescale 1ns / 1ps
module inode_cache_lfu_top #(
	parameter int CACHE_ENTRIES = icl_pkg::DEF_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [15:0] device,
	input  logic [31:0] inode_number,
	input  logic [5:0]  slot,
	input  logic        dirty,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [5:0]  entry,
	output logic [31:0] disk_block,
	output logic [5:0]  block_offset,
	output logic [31:0] out_inode,
	output logic [15:0] out_device,
	output logic [31:0] request_total,
	output logic [31:0] hit_total
);
	localparam int IW = $clog2(CACHE_ENTRIES);
	localparam logic [3:0] S_IDLE = 4'd0, S_MSCAN = 4'd1, S_MCHK = 4'd2,
		S_VSCAN = 4'd3, S_VCHK = 4'd4, S_UPD = 4'd5, S_PUTRD = 4'd6,
		S_PUTCHK = 4'd7, S_DIV = 4'd8, S_WAITD = 4'd9, S_OUT = 4'd10;
	logic [3:0] state_q;
	logic [6:0]  ipb_q;
	logic [31:0] start_q;
	logic        valid_q [CACHE_ENTRIES];
	logic        mod_q [CACHE_ENTRIES];
	logic [15:0] dev_mem [CACHE_ENTRIES];
	logic [31:0] ino_mem [CACHE_ENTRIES];
	logic [31:0] use_mem [CACHE_ENTRIES];
	logic [15:0] shr_mem [CACHE_ENTRIES];
	logic [15:0] rd_dev_q;
	logic [31:0] rd_ino_q, rd_use_q;
	logic [15:0] rd_shr_q;
	logic        rd_val_q, rd_mod_q;
	logic [IW-1:0] rd_idx_q;
	logic [IW:0] cnt_q;
	logic        dirty_q;
	logic [15:0] dev_q;
	logic [31:0] ino_q;
	logic [5:0]  slot_q;
	logic        found_q, free_q;
	logic [IW-1:0] pick_q;
	logic [31:0] pick_use_q;
	logic [31:0] req_q, hit_q;
	logic        we_c;
	logic [IW-1:0] wa_c;
	logic [31:0] we_use_c;
	logic [15:0] we_shr_c;
	icl_pkg::div_req_t dreq;
	logic        ddone;
	logic [31:0] dquot;
	logic [6:0]  drem;
	logic [6:0]  per_c;
	logic        match_c;
	logic        vcand_c;
	logic        rd_en_c;
	logic [IW-1:0] ra_c;

	assign per_c = (ipb_q == 7'd0) ? 7'd1 : ((ipb_q > 7'd64) ? 7'd64 : ipb_q);
	assign match_c = rd_val_q && rd_dev_q == dev_q && rd_ino_q == ino_q;
	assign vcand_c = rd_val_q && rd_shr_q == 16'd0 && (!found_q || rd_use_q < pick_use_q);
	assign in_stall = state_q != S_IDLE;
	assign request_total = req_q;
	assign hit_total = hit_q;

	icl_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .done(ddone),
		.quot(dquot), .rem(drem));

	always_comb begin
		rd_en_c = 1'b0;
		ra_c = cnt_q[IW-1:0];
		if (state_q == S_MSCAN || state_q == S_VSCAN) rd_en_c = 1'b1;
		if (state_q == S_PUTRD) begin
			rd_en_c = 1'b1;
			ra_c = IW'(slot_q);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en_c) begin
			rd_dev_q <= dev_mem[ra_c];
			rd_ino_q <= ino_mem[ra_c];
			rd_use_q <= use_mem[ra_c];
			rd_shr_q <= shr_mem[ra_c];
			rd_val_q <= valid_q[ra_c];
			rd_mod_q <= mod_q[ra_c];
			rd_idx_q <= ra_c;
		end
		if (we_c) begin
			use_mem[wa_c] <= we_use_c;
			shr_mem[wa_c] <= we_shr_c;
		end
		if (state_q == S_UPD && !found_q) begin
			dev_mem[pick_q] <= dev_q;
			ino_mem[pick_q] <= ino_q;
		end
	end

	always_comb begin
		we_c = 1'b0;
		wa_c = pick_q;
		we_use_c = rd_use_q;
		we_shr_c = rd_shr_q;
		if (state_q == S_UPD) begin
			we_c = 1'b1;
			if (found_q) begin
				we_use_c = (rd_use_q == 32'hFFFF_FFFF) ? rd_use_q : rd_use_q + 32'd1;
				we_shr_c = (rd_shr_q == 16'hFFFF) ? rd_shr_q : rd_shr_q + 16'd1;
			end else begin
				we_use_c = 32'd1;
				we_shr_c = 16'd1;
			end
		end
		if (state_q == S_PUTCHK && rd_val_q && rd_shr_q != 16'd0 &&
			32'(slot_q) < 32'(CACHE_ENTRIES)) begin
			we_c = 1'b1;
			wa_c = rd_idx_q;
			we_shr_c = rd_shr_q - 16'd1;
		end
	end

	always_comb begin
		dreq.start = 1'b0;
		dreq.dividend = ino_q - 32'd1;
		dreq.divisor = per_c;
		if (state_q == S_DIV) dreq.start = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ipb_q <= 7'd8;
			start_q <= '0;
			req_q <= '0;
			hit_q <= '0;
			out_valid <= 1'b0;
			cnt_q <= '0;
			found_q <= 1'b0;
			free_q <= 1'b0;
			pick_q <= '0;
			pick_use_q <= '0;
			for (int i = 0; i < CACHE_ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
				mod_q[i] <= 1'b0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					icl_pkg::CFG_IPB:   ipb_q <= cfg_data[6:0];
					icl_pkg::CFG_START: start_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					cnt_q <= '0;
					found_q <= 1'b0;
					free_q <= 1'b0;
					pick_q <= '0;
					if (command == icl_pkg::CMD_GET) begin
						req_q <= req_q + 32'd1;
						state_q <= S_MSCAN;
					end else state_q <= S_PUTRD;
				end
				S_MSCAN: state_q <= S_MCHK;
				S_MCHK: begin
					if (match_c) begin
						found_q <= 1'b1;
						pick_q <= rd_idx_q;
						hit_q <= hit_q + 32'd1;
						state_q <= S_UPD;
					end else if (cnt_q == (IW+1)'(CACHE_ENTRIES - 1)) begin
						cnt_q <= '0;
						state_q <= S_VSCAN;
					end else begin
						cnt_q <= cnt_q + (IW+1)'(1);
						state_q <= S_MSCAN;
					end
				end
				S_VSCAN: state_q <= S_VCHK;
				S_VCHK: begin
					if (!rd_val_q) begin
						free_q <= 1'b1;
						found_q <= 1'b0;
						pick_q <= rd_idx_q;
						state_q <= S_UPD;
					end else if (cnt_q == (IW+1)'(CACHE_ENTRIES - 1)) begin
						if (vcand_c) pick_q <= rd_idx_q;
						if (found_q || vcand_c) begin
							found_q <= 1'b0;
							free_q <= 1'b1;
							state_q <= S_UPD;
						end else state_q <= S_OUT;
					end else begin
						if (vcand_c) begin
							found_q <= 1'b1;
							pick_q <= rd_idx_q;
							pick_use_q <= rd_use_q;
						end
						cnt_q <= cnt_q + (IW+1)'(1);
						state_q <= S_VSCAN;
					end
				end
				S_UPD: begin
					if (!found_q || free_q) begin
						valid_q[pick_q] <= 1'b1;
						mod_q[pick_q] <= 1'b0;
					end
					state_q <= S_DIV;
				end
				S_PUTRD: state_q <= S_PUTCHK;
				S_PUTCHK: begin
					if (we_c) begin
						if (dirty_q && rd_shr_q != 16'd1) mod_q[rd_idx_q] <= 1'b1;
						else if (rd_shr_q == 16'd1) mod_q[rd_idx_q] <= 1'b0;
						state_q <= S_DIV;
					end else state_q <= S_OUT;
				end
				S_DIV: state_q <= S_WAITD;
				S_WAITD: if (ddone) state_q <= S_OUT;
				S_OUT: begin
					if (!out_valid) out_valid <= 1'b1;
					else if (!out_stall) begin
						out_valid <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers and result word
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			dev_q <= device;
			ino_q <= inode_number;
			slot_q <= slot;
			dirty_q <= dirty;
		end
		if (state_q == S_MCHK && match_c) begin
			status <= icl_pkg::ST_HIT;
			entry <= 6'(rd_idx_q);
		end
		if (state_q == S_VCHK) begin
			if (!rd_val_q) begin
				status <= icl_pkg::ST_FILL;
				entry <= 6'(rd_idx_q);
			end else if (cnt_q == (IW+1)'(CACHE_ENTRIES - 1)) begin
				if (found_q || vcand_c) begin
					status <= icl_pkg::ST_EVICT;
					entry <= vcand_c ? 6'(rd_idx_q) : 6'(pick_q);
				end else begin
					status <= icl_pkg::ST_NONE;
					entry <= '0;
					disk_block <= '0;
					block_offset <= '0;
					out_inode <= ino_q;
					out_device <= dev_q;
				end
			end
		end
		if (state_q == S_PUTCHK) begin
			entry <= slot_q;
			if (we_c) begin
				status <= (rd_shr_q == 16'd1 && (rd_mod_q || dirty_q)) ?
					icl_pkg::ST_WBACK : icl_pkg::ST_RELEASE;
				out_inode <= rd_ino_q;
				out_device <= rd_dev_q;
				ino_q <= rd_ino_q;
			end else begin
				status <= icl_pkg::ST_BADPUT;
				disk_block <= '0;
				block_offset <= '0;
				out_inode <= '0;
				out_device <= '0;
			end
		end
		if (state_q == S_UPD) begin
			out_inode <= ino_q;
			out_device <= dev_q;
		end
		if (state_q == S_WAITD && ddone) begin
			disk_block <= dquot + start_q;
			block_offset <= drem[5:0];
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == S_OUT)
		else $error("result shown outside output state");
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("accepted word did not start work");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(status) && $stable(entry))
		else $error("stalled result changed");
endmodule
